FILE: rtl/ccnn_pkg.sv
package ccnn_pkg;

    localparam int MAX_CITY_COUNT = 64;
    localparam int CITY_W = $clog2(MAX_CITY_COUNT);
    localparam int CNT_W = CITY_W + 1;
    localparam int DIST_W = 7;
    localparam int COST_W = 13;
    localparam int OP_W = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int RUN_W = 2;
    localparam int LEFT_W = 8;

    localparam logic [DIST_W-1:0] NO_CAND_LIMIT = DIST_W'(101);
    localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(3);
    localparam logic [COST_W-1:0] COST_ALL_ONES = '1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_DIST  = 2'd0,
        OP_LOAD_COLOR = 2'd1,
        OP_RUN        = 2'd2,
        OP_NONE       = 2'd3
    } opcode_t;

    typedef enum logic [0:0] {
        REG_CITY_COUNT = 1'b0,
        REG_UNUSED     = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic load_dist;
        logic load_color;
        logic run_begin;
        logic rd_color;
        logic init;
        logic scan;
        logic step;
        logic finish;
        logic out_rd;
        logic out_adv;
    } ccnn_cmd_t;

    typedef struct packed {
        logic n_one;
        logic start_last;
        logic scan_last;
        logic have;
        logic tour_last;
        logic out_last;
    } ccnn_sts_t;

endpackage

FILE: rtl/ccnn_if.sv
interface ccnn_req_if;
    logic                          valid;
    logic                          ready;
    logic [ccnn_pkg::OP_W-1:0]     opcode;
    logic [ccnn_pkg::CITY_W-1:0]   row;
    logic [ccnn_pkg::CITY_W-1:0]   col;
    logic [ccnn_pkg::DIST_W-1:0]   distance;
    logic                          color;

    modport source (output valid, opcode, row, col, distance, color, input ready);
    modport sink (input valid, opcode, row, col, distance, color, output ready);
endinterface

interface ccnn_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ccnn_pkg::CITY_W-1:0]   position;
    logic [ccnn_pkg::CITY_W-1:0]   city;
    logic [ccnn_pkg::COST_W-1:0]   tour_cost;
    logic                          found;
    logic                          last;

    modport source (output valid, position, city, tour_cost, found, last, input ready);
    modport sink (input valid, position, city, tour_cost, found, last, output ready);
endinterface

FILE: rtl/ccnn_cfg.sv
module ccnn_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ccnn_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ccnn_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ccnn_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [ccnn_pkg::CNT_W-1:0]      city_count
);
    import ccnn_pkg::*;

    logic [CNT_W-1:0] city_count_reg;
    logic [CNT_W-1:0] city_count_next;
    reg_index_t       reg_index;

    assign pready = 1'b1;
    assign reg_index = reg_index_t'(paddr[APB_ADDR_W-1]);

    always_comb
    begin
        city_count_next = city_count_reg;
        if (psel && penable && pwrite && pready && reg_index == REG_CITY_COUNT)
        begin
            city_count_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            city_count_reg <= CNT_W'(MAX_CITY_COUNT);
        end
        else
        begin
            city_count_reg <= city_count_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_CITY_COUNT)
        begin
            prdata = APB_DATA_W'(city_count_reg);
        end
    end

    // clamp to 1..max
    always_comb
    begin
        city_count = city_count_reg;
        if (city_count_reg == '0)
        begin
            city_count = CNT_W'(1);
        end
        else if (city_count_reg > CNT_W'(MAX_CITY_COUNT))
        begin
            city_count = CNT_W'(MAX_CITY_COUNT);
        end
    end

endmodule

FILE: rtl/ccnn_ctrl.sv
module ccnn_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic [ccnn_pkg::OP_W-1:0]  req_opcode,
    output logic                       req_ready,
    input  logic                       rsp_ready,
    output logic                       rsp_valid,
    input  ccnn_pkg::ccnn_sts_t        sts,
    output ccnn_pkg::ccnn_cmd_t        cmd
);
    import ccnn_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_RDCOL  = 9'b000000010,
        ST_INIT   = 9'b000000100,
        ST_SCAN   = 9'b000001000,
        ST_LASTEV = 9'b000010000,
        ST_STEP   = 9'b000100000,
        ST_NEXT   = 9'b001000000,
        ST_ORD    = 9'b010000000,
        ST_OSHOW  = 9'b100000000
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    opcode_t op;
    logic    req_beat;

    assign op = opcode_t'(req_opcode);
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_OSHOW);
    assign req_beat = req_valid && req_ready;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_beat)
                begin
                    case (op)
                        OP_LOAD_DIST:  cmd.load_dist = 1'b1;
                        OP_LOAD_COLOR: cmd.load_color = 1'b1;
                        OP_RUN:
                        begin
                            cmd.run_begin = 1'b1;
                            state_next = ST_RDCOL;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RDCOL:
            begin
                cmd.rd_color = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.init = 1'b1;
                state_next = sts.n_one ? ST_NEXT : ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_LASTEV;
                end
            end
            ST_LASTEV:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.step = 1'b1;
                if (!sts.have || sts.tour_last)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_NEXT:
            begin
                cmd.finish = 1'b1;
                state_next = sts.start_last ? ST_ORD : ST_RDCOL;
            end
            ST_ORD:
            begin
                cmd.out_rd = 1'b1;
                state_next = ST_OSHOW;
            end
            ST_OSHOW:
            begin
                if (rsp_ready)
                begin
                    cmd.out_adv = 1'b1;
                    state_next = sts.out_last ? ST_IDLE : ST_ORD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/ccnn_datapath.sv
module ccnn_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ccnn_pkg::ccnn_cmd_t          cmd,
    output ccnn_pkg::ccnn_sts_t          sts,
    input  logic [ccnn_pkg::CNT_W-1:0]   city_count,
    input  logic [ccnn_pkg::CITY_W-1:0]  row,
    input  logic [ccnn_pkg::CITY_W-1:0]  col,
    input  logic [ccnn_pkg::DIST_W-1:0]  distance,
    input  logic                         color,
    output logic [ccnn_pkg::CITY_W-1:0]  position,
    output logic [ccnn_pkg::CITY_W-1:0]  city,
    output logic [ccnn_pkg::COST_W-1:0]  tour_cost,
    output logic                         found,
    output logic                         last
);
    import ccnn_pkg::*;

    localparam int DIST_DEPTH = MAX_CITY_COUNT * MAX_CITY_COUNT;
    localparam int TOUR_DEPTH = 2 * MAX_CITY_COUNT;

    logic [DIST_W-1:0] dist_mem [DIST_DEPTH];
    logic              color_mem [MAX_CITY_COUNT];
    logic [CITY_W-1:0] tour_mem [TOUR_DEPTH];

    logic [DIST_W-1:0] dist_rdata_reg;
    logic              color_rdata_reg;
    logic [CITY_W-1:0] tour_rdata_reg;

    logic [CITY_W-1:0] s_reg;
    logic [CITY_W-1:0] j_reg;
    logic [CITY_W-1:0] j_d_reg;
    logic              pipe_valid_reg;
    logic [CITY_W-1:0] idx_reg;
    logic [CITY_W-1:0] k_reg;
    logic [CITY_W-1:0] curr_reg;
    logic              curr_color_reg;
    logic [CITY_W-1:0] next_city_reg;
    logic              next_color_reg;
    logic [DIST_W-1:0] min_reg;
    logic              have_reg;
    logic [MAX_CITY_COUNT-1:0] visited_reg;
    logic signed [LEFT_W-1:0]  red_reg;
    logic signed [LEFT_W-1:0]  blue_reg;
    logic [RUN_W-1:0]  run_reg;
    logic [COST_W-1:0] sum_reg;
    logic              tour_ok_reg;
    logic [COST_W-1:0] best_cost_reg;
    logic              best_bank_reg;
    logic              found_reg;

    logic [CITY_W-1:0] nm1;
    logic [CITY_W-1:0] color_raddr;
    logic signed [LEFT_W-1:0] half;
    logic signed [LEFT_W+1:0] red_w;
    logic signed [LEFT_W+1:0] blue_w;
    logic signed [LEFT_W+1:0] red_m3;
    logic signed [LEFT_W+1:0] blue_m3;
    logic              red_block;
    logic              blue_block;
    logic              cand;
    logic              tour_we;
    logic [CITY_W:0]   tour_waddr;
    logic [CITY_W-1:0] tour_wdata;

    assign nm1 = city_count[CITY_W-1:0] - CITY_W'(1);
    assign half = LEFT_W'(city_count[CNT_W-1:1]);
    assign color_raddr = cmd.rd_color ? s_reg : j_reg;

    // balance rule, fixed for the duration of a step
    assign red_w = {{2{red_reg[LEFT_W-1]}}, red_reg};
    assign blue_w = {{2{blue_reg[LEFT_W-1]}}, blue_reg};
    assign red_m3 = ((red_w - 10'sd1) <<< 1) + (red_w - 10'sd1);
    assign blue_m3 = ((blue_w - 10'sd1) <<< 1) + (blue_w - 10'sd1);
    assign red_block = (red_m3 < blue_w) && (red_reg > 8'sd1);
    assign blue_block = (blue_m3 < red_w) && (blue_reg > 8'sd1);

    always_comb
    begin
        cand = (dist_rdata_reg < min_reg) && (j_d_reg != curr_reg) && !visited_reg[j_d_reg];
        if (color_rdata_reg == curr_color_reg && run_reg >= RUN_LIMIT)
        begin
            cand = 1'b0;
        end
        if (!color_rdata_reg && red_block)
        begin
            cand = 1'b0;
        end
        if (color_rdata_reg && blue_block)
        begin
            cand = 1'b0;
        end
    end

    always_comb
    begin
        tour_we = 1'b0;
        tour_waddr = {~best_bank_reg, CITY_W'(0)};
        tour_wdata = s_reg;
        if (cmd.init)
        begin
            tour_we = 1'b1;
        end
        else if (cmd.step && have_reg)
        begin
            tour_we = 1'b1;
            tour_waddr = {~best_bank_reg, idx_reg};
            tour_wdata = next_city_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_dist)
        begin
            dist_mem[{row, col}] <= distance;
        end
        dist_rdata_reg <= dist_mem[{curr_reg, j_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_color)
        begin
            color_mem[row] <= color;
        end
        color_rdata_reg <= color_mem[color_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tour_we)
        begin
            tour_mem[tour_waddr] <= tour_wdata;
        end
        if (cmd.out_rd)
        begin
            tour_rdata_reg <= tour_mem[{best_bank_reg, k_reg}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg <= '0;
            j_reg <= '0;
            j_d_reg <= '0;
            pipe_valid_reg <= 1'b0;
            idx_reg <= '0;
            k_reg <= '0;
            curr_reg <= '0;
            curr_color_reg <= 1'b0;
            next_city_reg <= '0;
            next_color_reg <= 1'b0;
            min_reg <= NO_CAND_LIMIT;
            have_reg <= 1'b0;
            visited_reg <= '0;
            red_reg <= '0;
            blue_reg <= '0;
            run_reg <= RUN_W'(1);
            sum_reg <= '0;
            tour_ok_reg <= 1'b0;
            best_cost_reg <= COST_ALL_ONES;
            best_bank_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            pipe_valid_reg <= cmd.scan;
            j_d_reg <= j_reg;
            if (cmd.run_begin)
            begin
                best_cost_reg <= COST_ALL_ONES;
                found_reg <= 1'b0;
                s_reg <= '0;
            end
            if (cmd.init)
            begin
                visited_reg <= MAX_CITY_COUNT'(1) << s_reg;
                run_reg <= RUN_W'(1);
                red_reg <= color_rdata_reg ? half : half - 8'sd1;
                blue_reg <= color_rdata_reg ? half - 8'sd1 : half;
                curr_reg <= s_reg;
                curr_color_reg <= color_rdata_reg;
                idx_reg <= CITY_W'(1);
                sum_reg <= '0;
                tour_ok_reg <= (nm1 == '0);
                j_reg <= '0;
                min_reg <= NO_CAND_LIMIT;
                have_reg <= 1'b0;
            end
            if (cmd.scan)
            begin
                j_reg <= j_reg + CITY_W'(1);
            end
            if (pipe_valid_reg && cand)
            begin
                min_reg <= dist_rdata_reg;
                next_city_reg <= j_d_reg;
                next_color_reg <= color_rdata_reg;
                have_reg <= 1'b1;
            end
            if (cmd.step)
            begin
                j_reg <= '0;
                min_reg <= NO_CAND_LIMIT;
                have_reg <= 1'b0;
                if (have_reg)
                begin
                    visited_reg[next_city_reg] <= 1'b1;
                    if (next_color_reg)
                    begin
                        blue_reg <= blue_reg - 8'sd1;
                    end
                    else
                    begin
                        red_reg <= red_reg - 8'sd1;
                    end
                    if (curr_color_reg == next_color_reg)
                    begin
                        run_reg <= (run_reg == RUN_LIMIT) ? RUN_LIMIT : run_reg + RUN_W'(1);
                    end
                    else
                    begin
                        run_reg <= RUN_W'(1);
                    end
                    sum_reg <= sum_reg + COST_W'(min_reg);
                    curr_reg <= next_city_reg;
                    curr_color_reg <= next_color_reg;
                    idx_reg <= idx_reg + CITY_W'(1);
                    tour_ok_reg <= (idx_reg == nm1);
                end
            end
            if (cmd.finish)
            begin
                if (tour_ok_reg && sum_reg < best_cost_reg)
                begin
                    best_cost_reg <= sum_reg;
                    best_bank_reg <= ~best_bank_reg;
                    found_reg <= 1'b1;
                end
                s_reg <= s_reg + CITY_W'(1);
                k_reg <= '0;
            end
            if (cmd.out_adv)
            begin
                k_reg <= k_reg + CITY_W'(1);
            end
        end
    end

    assign sts.n_one = (nm1 == '0);
    assign sts.start_last = (s_reg == nm1);
    assign sts.scan_last = (j_reg == nm1);
    assign sts.have = have_reg;
    assign sts.tour_last = (idx_reg == nm1);
    assign sts.out_last = !found_reg || (k_reg == nm1);

    assign position = found_reg ? k_reg : '0;
    assign city = found_reg ? tour_rdata_reg : '0;
    assign tour_cost = found_reg ? best_cost_reg : '0;
    assign found = found_reg;
    assign last = sts.out_last;

endmodule

FILE: rtl/color_constrained_nearest_neighbor_tour.sv
// Greedy nearest-neighbor tour search over up to 64 cities with a red/blue
// run and balance rule. Load beats (distance entry or city color) are taken
// while idle and do not block the input. A run beat blocks the input until
// its results are taken. The search examines one candidate city per cycle
// through the single read port of the distance memory, one greedy step at a
// time from every start city. Then it emits n result beats (one if no start
// gives a complete tour), each read from the tour memory and then held until
// taken. No clearing pass is needed after reset; distances and colors must be
// loaded before they are used.
module color_constrained_nearest_neighbor_tour (
    input  logic                            clk,
    input  logic                            rst_n,
    ccnn_req_if.sink                        req,
    ccnn_rsp_if.source                      rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ccnn_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ccnn_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ccnn_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import ccnn_pkg::*;

    ccnn_cmd_t        cmd;
    ccnn_sts_t        sts;
    logic [CNT_W-1:0] city_count;

    ccnn_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .city_count (city_count)
    );

    ccnn_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_opcode (req.opcode),
        .req_ready  (req.ready),
        .rsp_ready  (rsp.ready),
        .rsp_valid  (rsp.valid),
        .sts        (sts),
        .cmd        (cmd)
    );

    ccnn_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .city_count (city_count),
        .row        (req.row),
        .col        (req.col),
        .distance   (req.distance),
        .color      (req.color),
        .position   (rsp.position),
        .city       (rsp.city),
        .tour_cost  (rsp.tour_cost),
        .found      (rsp.found),
        .last       (rsp.last)
    );

endmodule

FILE: rtl/ccnn_chk.sv
module ccnn_chk (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [ccnn_pkg::CITY_W-1:0]   position,
    input  logic [ccnn_pkg::CITY_W-1:0]   city,
    input  logic [ccnn_pkg::COST_W-1:0]   tour_cost,
    input  logic                          found,
    input  logic                          last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({position, city, tour_cost, found, last}))
        else $error("result beat changed while stalled");

    // no input taken while results are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is shown");

    // a beat that is not last is followed by more of the same run
    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> !in_ready)
        else $error("run ended without a last beat");

    // a run with no tour gives one all-zero last beat
    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> last && position == '0 && city == '0 && tour_cost == '0)
        else $error("bad no-tour result");

endmodule

bind color_constrained_nearest_neighbor_tour ccnn_chk u_ccnn_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .position  (rsp.position),
    .city      (rsp.city),
    .tour_cost (rsp.tour_cost),
    .found     (rsp.found),
    .last      (rsp.last)
);

FILE: verif/color_constrained_nearest_neighbor_tour_check.sv
module color_constrained_nearest_neighbor_tour_check
    import ccnn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ccnn_req_if                   req,
    ccnn_rsp_if                   rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    failures,
    output int                    pending_beats
);

    typedef struct packed {
        logic [CITY_W-1:0] position;
        logic [CITY_W-1:0] city;
        logic [COST_W-1:0] tour_cost;
        logic              found;
        logic              last;
    } tour_beat_t;

    tour_beat_t        tour_beats_due [$];
    tour_beat_t        due;
    logic [DIST_W-1:0] dist_mem [MAX_CITY_COUNT][MAX_CITY_COUNT];
    logic              color_mem [MAX_CITY_COUNT];
    logic [CNT_W-1:0]  city_count_reg;
    int                errors;

    function automatic void compare_field(string field, logic [31:0] expected,
                                          logic [31:0] actual);
        if (expected !== actual)
        begin
            $error("%s: expected %0d, got %0d", field, expected, actual);
            errors++;
        end
    endfunction

    // greedy walk from every start city, keep the strictly cheapest complete tour
    function automatic void plan_best_tour();
        int                n;
        int                start;
        int                idx;
        int                j;
        int                cur;
        int                next_city;
        int                min_d;
        int                d;
        int                sum;
        int                best_cost;
        int                red_left;
        int                blue_left;
        int                run_len;
        bit                complete;
        bit                skip;
        bit                found;
        bit                visited [MAX_CITY_COUNT];
        logic [CITY_W-1:0] walk [MAX_CITY_COUNT];
        logic [CITY_W-1:0] best [MAX_CITY_COUNT];
        tour_beat_t        beat;

        if (city_count_reg == 0)
            n = 1;
        else if (city_count_reg > MAX_CITY_COUNT)
            n = MAX_CITY_COUNT;
        else
            n = int'(city_count_reg);
        best_cost = int'(COST_ALL_ONES);
        found = 1'b0;
        for (start = 0; start < n; start++)
        begin
            foreach (visited[i])
                visited[i] = 1'b0;
            run_len = 1;
            red_left = n / 2;
            blue_left = n / 2;
            if (color_mem[start])
                blue_left--;
            else
                red_left--;
            visited[start] = 1'b1;
            walk[0] = CITY_W'(start);
            cur = start;
            sum = 0;
            complete = 1'b1;
            for (idx = 1; idx < n && complete; idx++)
            begin
                min_d = int'(NO_CAND_LIMIT);
                next_city = 0;
                complete = 1'b0;
                for (j = 0; j < n; j++)
                begin
                    d = int'(dist_mem[cur][j]);
                    skip = (d >= min_d) || (j == cur) || visited[j]
                        || (color_mem[cur] == color_mem[j] && run_len >= int'(RUN_LIMIT))
                        || (!color_mem[j] && (red_left - 1) * 3 < blue_left && red_left > 1)
                        || (color_mem[j] && (blue_left - 1) * 3 < red_left && blue_left > 1);
                    if (!skip)
                    begin
                        next_city = j;
                        min_d = d;
                        complete = 1'b1;
                    end
                end
                if (complete)
                begin
                    walk[idx] = CITY_W'(next_city);
                    sum += min_d;
                    visited[next_city] = 1'b1;
                    if (color_mem[next_city])
                        blue_left--;
                    else
                        red_left--;
                    run_len = (color_mem[cur] == color_mem[next_city]) ? run_len + 1 : 1;
                    cur = next_city;
                end
            end
            if (complete && sum < best_cost)
            begin
                best_cost = sum;
                best = walk;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            beat = '0;
            beat.last = 1'b1;
            tour_beats_due = {tour_beats_due, beat};
        end
        else
        begin
            for (idx = 0; idx < n; idx++)
            begin
                beat.position = CITY_W'(idx);
                beat.city = best[idx];
                beat.tour_cost = COST_W'(best_cost);
                beat.found = 1'b1;
                beat.last = (idx == n - 1);
                tour_beats_due = {tour_beats_due, beat};
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            city_count_reg = CNT_W'(MAX_CITY_COUNT);
            tour_beats_due.delete();
            errors = 0;
            failures <= 0;
            pending_beats <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == {REG_CITY_COUNT, 2'b00})
                city_count_reg = pwdata[CNT_W-1:0];
            if (req.valid && req.ready)
            begin
                case (opcode_t'(req.opcode))
                    OP_LOAD_DIST:  dist_mem[req.row][req.col] = req.distance;
                    OP_LOAD_COLOR: color_mem[req.row] = req.color;
                    OP_RUN:        plan_best_tour();
                    default:       ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (tour_beats_due.size() == 0)
                begin
                    $error("result beat with nothing expected: city %0d cost %0d",
                           rsp.city, rsp.tour_cost);
                    errors++;
                end
                else
                begin
                    due = tour_beats_due.pop_front();
                    compare_field("position", 32'(due.position), 32'(rsp.position));
                    compare_field("city", 32'(due.city), 32'(rsp.city));
                    compare_field("tour_cost", 32'(due.tour_cost), 32'(rsp.tour_cost));
                    compare_field("found", 32'(due.found), 32'(rsp.found));
                    compare_field("last", 32'(due.last), 32'(rsp.last));
                end
            end
            failures <= errors;
            pending_beats <= tour_beats_due.size();
        end
    end

endmodule

FILE: verif/color_constrained_nearest_neighbor_tour_test.sv
module color_constrained_nearest_neighbor_tour_test;
    import ccnn_pkg::*;

    localparam int WATCHDOG_LIMIT = 5_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES = 20;
    localparam int SEARCHES_PER_PHASE = 2;
    localparam int MAX_TEST_CITIES = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic                  pready;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    int                    send_idle_pct;
    int                    recv_stall_pct;
    int                    failures;
    int                    pending_beats;
    int                    beats_sent;
    int                    searches_sent;
    int                    results_seen;
    int                    quiet_cycles;
    int                    phase_send_idle [4] = '{0, 84, 0, 22};
    int                    phase_recv_stall [4] = '{0, 0, 84, 22};

    ccnn_req_if req_ch ();
    ccnn_rsp_if rsp_ch ();

    color_constrained_nearest_neighbor_tour dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    color_constrained_nearest_neighbor_tour_check tour_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .failures      (failures),
        .pending_beats (pending_beats)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        rsp_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("no beat accepted for %0d cycles", quiet_cycles);
                $display("FAIL color_constrained_nearest_neighbor_tour");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
            if (rsp_ch.valid && rsp_ch.ready)
                results_seen <= results_seen + 1;
        end
    end

    function automatic logic [DIST_W-1:0] rand_distance();
        if ($urandom_range(99) < 85)
            return DIST_W'($urandom_range(100));
        return DIST_W'($urandom_range(101, 127));
    endfunction

    task automatic send_beat(opcode_t op, logic [CITY_W-1:0] row, logic [CITY_W-1:0] col,
                             logic [DIST_W-1:0] distance, logic color);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.opcode <= op;
        req_ch.row <= row;
        req_ch.col <= col;
        req_ch.distance <= distance;
        req_ch.color <= color;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        beats_sent++;
        if (op == OP_RUN)
            searches_sent++;
    endtask

    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every expected result beat is back and the last load has landed
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_search();
        send_beat(OP_RUN, CITY_W'($urandom_range(63)), CITY_W'($urandom_range(63)),
                  DIST_W'($urandom_range(127)), 1'($urandom_range(1)));
    endtask

    task automatic random_search();
        int   n;
        int   pick;
        int   r;
        int   c;
        logic shade;

        pick = $urandom_range(99);
        if (pick < 10)
            n = $urandom_range(1, 2);
        else if (pick < 85)
            n = $urandom_range(3, 5);
        else
            n = $urandom_range(6, MAX_TEST_CITIES);
        settle();
        apb_write({REG_CITY_COUNT, 2'b00}, (n == 1 && $urandom_range(1) == 1) ? 0 : n);
        case ($urandom_range(3))
            0:
            begin
                for (r = 0; r < n; r++)
                    for (c = 0; c < n; c++)
                        send_beat(OP_LOAD_DIST, CITY_W'(r), CITY_W'(c), rand_distance(),
                                  1'($urandom_range(1)));
                for (r = 0; r < n; r++)
                    send_beat(OP_LOAD_COLOR, CITY_W'(r), CITY_W'($urandom_range(63)),
                              DIST_W'($urandom_range(127)), 1'($urandom_range(1)));
            end
            1:
            begin
                // one color throughout, at most one city of the other
                shade = 1'($urandom_range(1));
                pick = $urandom_range(n);
                for (r = 0; r < n; r++)
                    send_beat(OP_LOAD_COLOR, CITY_W'(r), CITY_W'($urandom_range(63)),
                              DIST_W'($urandom_range(127)), shade ^ (r == pick));
                repeat ($urandom_range(3))
                    send_beat(OP_LOAD_DIST, CITY_W'($urandom_range(n - 1)),
                              CITY_W'($urandom_range(n - 1)), rand_distance(),
                              1'($urandom_range(1)));
            end
            2:
            begin
                // narrow values so ties are common
                for (r = 0; r < n; r++)
                    for (c = 0; c < n; c++)
                        send_beat(OP_LOAD_DIST, CITY_W'(r), CITY_W'(c),
                                  ($urandom_range(4) == 0) ? DIST_W'(101)
                                                           : DIST_W'($urandom_range(2)),
                                  1'($urandom_range(1)));
            end
            default:
            begin
                repeat ($urandom_range(1, 6))
                begin
                    pick = $urandom_range(2);
                    send_beat((pick == 0) ? OP_LOAD_DIST : (pick == 1) ? OP_LOAD_COLOR
                                                                     : OP_NONE,
                              CITY_W'($urandom_range(63)), CITY_W'($urandom_range(63)),
                              rand_distance(), 1'($urandom_range(1)));
                end
            end
        endcase
        run_search();
    endtask

    initial
    begin
        int ph;
        int r;
        int c;

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.opcode = OP_NONE;
        req_ch.row = '0;
        req_ch.col = '0;
        req_ch.distance = '0;
        req_ch.color = 1'b0;
        rsp_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        beats_sent = 0;
        searches_sent = 0;
        results_seen = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = phase_send_idle[ph];
            recv_stall_pct <= phase_recv_stall[ph];
            if (ph == 0)
            begin
                apb_write({REG_UNUSED, 2'b00}, $urandom);
                // count of zero runs a single city
                apb_write({REG_CITY_COUNT, 2'b00}, 0);
                send_beat(OP_LOAD_COLOR, CITY_W'(0), CITY_W'(0), DIST_W'(0), 1'b1);
                send_beat(OP_LOAD_DIST, CITY_W'(0), CITY_W'(0), DIST_W'(0), 1'b0);
                send_beat(OP_RUN, CITY_W'(63), CITY_W'(63), DIST_W'(127), 1'b1);
                send_beat(OP_NONE, CITY_W'($urandom_range(63)), CITY_W'($urandom_range(63)),
                          DIST_W'($urandom_range(127)), 1'($urandom_range(1)));
                send_beat(OP_LOAD_DIST, CITY_W'(63), CITY_W'(63), DIST_W'(127), 1'b1);
                send_beat(OP_LOAD_DIST, CITY_W'(63), CITY_W'(0), DIST_W'(100), 1'b0);
                send_beat(OP_LOAD_DIST, CITY_W'(0), CITY_W'(63), DIST_W'(0), 1'b1);
                send_beat(OP_LOAD_COLOR, CITY_W'(63), CITY_W'(0), DIST_W'(0), 1'b0);
                settle();
                apb_write({REG_CITY_COUNT, 2'b00}, 2);
                send_beat(OP_LOAD_COLOR, CITY_W'(1), CITY_W'(0), DIST_W'(0), 1'b0);
                send_beat(OP_LOAD_DIST, CITY_W'(0), CITY_W'(1), DIST_W'(101), 1'b0);
                send_beat(OP_LOAD_DIST, CITY_W'(1), CITY_W'(0), DIST_W'(127), 1'b0);
                send_beat(OP_LOAD_DIST, CITY_W'(1), CITY_W'(1), DIST_W'(0), 1'b0);
                // both starts hit a dead end
                send_beat(OP_RUN, CITY_W'(0), CITY_W'(0), DIST_W'(0), 1'b0);
                send_beat(OP_LOAD_DIST, CITY_W'(0), CITY_W'(1), DIST_W'(100), 1'b1);
                send_beat(OP_RUN, CITY_W'(0), CITY_W'(0), DIST_W'(0), 1'b0);
                for (r = 0; r < MAX_TEST_CITIES; r++)
                    for (c = 0; c < MAX_TEST_CITIES; c++)
                        send_beat(OP_LOAD_DIST, CITY_W'(r), CITY_W'(c), rand_distance(),
                                  1'($urandom_range(1)));
                for (r = 0; r < MAX_TEST_CITIES; r++)
                    send_beat(OP_LOAD_COLOR, CITY_W'(r), CITY_W'($urandom_range(63)),
                              DIST_W'($urandom_range(127)), 1'($urandom_range(1)));
            end
            repeat (SEARCHES_PER_PHASE) random_search();
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("sent %0d request beats with %0d searches, checked %0d result beats",
                 beats_sent, searches_sent, results_seen);
        $display("city counts 0 to 8 and an unknown register written, four idle mixes");
        if (failures == 0)
            $display("PASS color_constrained_nearest_neighbor_tour");
        else
            $display("FAIL color_constrained_nearest_neighbor_tour");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ccnn_pkg.sv
rtl/ccnn_if.sv
rtl/ccnn_cfg.sv
rtl/ccnn_ctrl.sv
rtl/ccnn_datapath.sv
rtl/color_constrained_nearest_neighbor_tour.sv
rtl/ccnn_chk.sv
verif/color_constrained_nearest_neighbor_tour_check.sv
verif/color_constrained_nearest_neighbor_tour_test.sv
